>>> design/lphi_pkg.sv
// types and constants shared by the linear probing hash insert block
`timescale 1ns / 1ps
`default_nettype none

package lphi_pkg;

    // key width and the largest table size the 5-bit register can name
    localparam int KEY_W          = 31;
    localparam int HANDLE_W       = 32;
    localparam int SIZE_W         = 5;
    localparam int MAX_TABLE_SIZE = 31;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 5'd16;

    // register index decoded from paddr[2]
    localparam logic REG_TABLE_SIZE = 1'b0;

    localparam logic STATUS_PLACED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] record_handle;
    } in_word_t;

    typedef struct packed {
        logic [3:0] slot;
        logic       status;
    } result_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_CHK
    } state_t;

endpackage

`default_nettype wire

>>> design/linear_probe_hash_insert_core.sv
// top level of the linear probing hash insert block
`timescale 1ns / 1ps
`default_nettype none

// Inserts one record handle per command word into a linear probing table.
// Command channel: drive cmd and raise start; the word is taken at a clock
// edge where start is high and busy is low. Result channel: done is high
// for exactly one cycle with the result word (slot, status); the receiver
// cannot stall it, so it must sample on that cycle.
// Configuration: an APB-style port, register table_size at byte address 0,
// written with the usual setup and access cycles; pready is always high.
// Per word: a one-bit-per-cycle remainder unit forms key modulo table
// size over the 31 key bits, then each probed slot takes an ST_RD step
// for the occupancy memory read and an ST_CHK step to check and write
// back. The number of probes runs from 1 to the table size; busy drops
// together with done so a new word can follow.
// Reset: table_size returns to 16 and the occupancy memory is cleared by a
// pass of one slot per cycle over min(TABLE_DEPTH, 31) slots, during which
// busy stays high; configuration writes are taken during that pass.
module linear_probe_hash_insert_core
    import lphi_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire in_word_t     cmd,
    output logic              done,
    output result_word_t      result,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // slots at or above the largest table size are never reached
    localparam int SLOTS = (TABLE_DEPTH < MAX_TABLE_SIZE) ? TABLE_DEPTH : MAX_TABLE_SIZE;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam logic [SIZE_W:0] SLOTS_CMP = (SIZE_W + 1)'(SLOTS);
    localparam logic [CW-1:0]   SLOTS_C   = CW'(SLOTS);
    localparam logic [CW-1:0]   LAST_SLOT = CW'(SLOTS - 1);
    localparam logic [4:0]      KEY_LAST  = 5'(KEY_W - 1);

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   table_size_reg;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [4:0]          bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       home_reg, home_next;
    logic [CW-1:0]       probe_reg, probe_next;
    logic [CW-1:0]       clr_reg, clr_next;
    logic                done_reg, done_next;
    result_word_t        result_reg, result_next;

    logic [CW-1:0]       eff_size;
    logic [CW:0]         trial;
    logic [CW-1:0]       probe_inc;
    logic                cfg_wr;

    logic                occ_mem [SLOTS];
    logic [HANDLE_W-1:0] rec_mem [SLOTS];
    logic                occ_rd_reg;
    logic                occ_we;
    logic                occ_wdata;
    logic                rec_we;
    logic [AW-1:0]       mem_addr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_TABLE_SIZE))
        begin
            table_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TABLE_SIZE)
        begin
            prdata = {{(32 - SIZE_W){1'b0}}, table_size_reg};
        end
    end

    // size zero acts as one, sizes past the table are clamped
    always_comb
    begin
        priority if (table_size_reg == '0)
        begin
            eff_size = CW'(1);
        end
        else if ({1'b0, table_size_reg} > SLOTS_CMP)
        begin
            eff_size = SLOTS_C;
        end
        else
        begin
            eff_size = CW'(table_size_reg);
        end
    end

    // restoring remainder step, rem stays below n
    assign trial     = {rem_reg, key_reg[KEY_W-1]};
    assign probe_inc = probe_reg + CW'(1);

    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next    = rem_reg;
        n_next      = n_reg;
        home_next   = home_reg;
        probe_next  = probe_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        occ_we      = 1'b0;
        occ_wdata   = 1'b0;
        rec_we      = 1'b0;
        mem_addr    = probe_reg[AW-1:0];
        busy        = 1'b1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                occ_we   = 1'b1;
                mem_addr = clr_reg[AW-1:0];
                clr_next = clr_reg + CW'(1);
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    key_next     = cmd.key;
                    handle_next  = cmd.record_handle;
                    bit_cnt_next = KEY_LAST;
                    rem_next     = '0;
                    n_next       = eff_size;
                    state_next   = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (trial >= {1'b0, n_reg})
                begin
                    rem_next = CW'(trial - {1'b0, n_reg});
                end
                else
                begin
                    rem_next = trial[CW-1:0];
                end
                key_next     = {key_reg[KEY_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 5'd1;
                if (bit_cnt_reg == '0)
                begin
                    home_next  = rem_next;
                    probe_next = rem_next;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                priority if (!occ_rd_reg)
                begin
                    occ_we      = 1'b1;
                    occ_wdata   = 1'b1;
                    rec_we      = 1'b1;
                    done_next   = 1'b1;
                    result_next = '{slot: 4'(probe_reg), status: STATUS_PLACED};
                    state_next  = ST_IDLE;
                end
                else if (probe_inc >= n_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{slot: 4'(home_reg), status: STATUS_FULL};
                    state_next  = ST_IDLE;
                end
                else
                begin
                    probe_next = probe_inc;
                    state_next = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            bit_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            bit_cnt_reg <= bit_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
        rem_reg    <= rem_next;
        n_reg      <= n_next;
        home_reg   <= home_next;
        probe_reg  <= probe_next;
        result_reg <= result_next;
    end

    // occupancy and record memories, one write port each, registered read of occupancy
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[mem_addr] <= occ_wdata;
        end
        occ_rd_reg <= occ_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[mem_addr] <= handle_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_CHK))
        else $error("result word without a slot check");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK) |-> (probe_reg < n_reg) && (home_reg <= probe_reg))
        else $error("probe outside home..size range");

    a_mod_to_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) && (bit_cnt_reg == '0) |=> (state_reg == ST_RD))
        else $error("remainder unit did not hand over to probe");

    a_write_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        rec_we |-> !occ_rd_reg && (state_reg == ST_CHK))
        else $error("record written into an occupied slot");

    a_busy_while_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> busy)
        else $error("busy low while an item is in flight");

endmodule

`default_nettype wire

>>> tb/sv/tb_linear_probe_hash_insert_core.sv
// self-checking testbench for the linear probing hash insert block
`timescale 1ns / 1ps

module tb_linear_probe_hash_insert_core;
    import lphi_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [2:0] ADDR_TABLE_SIZE = 3'd0;
    localparam logic [2:0] ADDR_UNUSED     = 3'd4;

    // tracks the table contents and the outcome due for each accepted word
    class insert_tracker;
        logic [SIZE_W-1:0]   size_reg;
        bit                  occupied[DEPTH];
        logic [HANDLE_W-1:0] records[DEPTH];
        result_word_t        outcomes_due[$];
        int                  mismatches;

        function new();
            size_reg   = TABLE_SIZE_RESET;
            mismatches = 0;
            foreach (occupied[i])
                occupied[i] = 1'b0;
        endfunction

        function void set_size(logic [SIZE_W-1:0] value);
            size_reg = value;
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        function void note_insert(in_word_t w);
            int unsigned  span;
            int unsigned  home;
            int unsigned  s;
            bit           placed;
            result_word_t r;
            span = size_reg;
            if (span == 0)
                span = 1;
            if (span > DEPTH)
                span = DEPTH;
            home     = w.key % span;
            r.slot   = home[3:0];
            r.status = STATUS_FULL;
            placed   = 1'b0;
            // walk upward from home, no wrap
            for (s = home; s < span && !placed; s++)
            begin
                if (!occupied[s])
                begin
                    occupied[s] = 1'b1;
                    records[s]  = w.record_handle;
                    r.slot      = s[3:0];
                    r.status    = STATUS_PLACED;
                    placed      = 1'b1;
                end
            end
            outcomes_due.push_back(r);
        endfunction

        function void check_outcome(result_word_t got);
            result_word_t want;
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: result word with none due, slot %0d status %0d",
                         $time, got.slot, got.status);
                mismatches++;
                return;
            end
            want = outcomes_due.pop_front();
            if (got.slot !== want.slot)
            begin
                $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         start;
    logic         busy;
    in_word_t     cmd;
    logic         done;
    result_word_t result;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    insert_tracker sb;
    int unsigned   cycles = 0;

    linear_probe_hash_insert_core #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_outcome(result);
    end

    task automatic apb_xfer(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write a register, then read table_size back
    task automatic set_register(input logic [2:0] addr, input logic [31:0] data);
        logic [31:0] rd;
        apb_xfer(1'b1, addr, data, rd);
        if (addr[2] == REG_TABLE_SIZE)
            sb.set_size(data[SIZE_W-1:0]);
        apb_xfer(1'b0, ADDR_TABLE_SIZE, 32'd0, rd);
        if (rd !== {{(32-SIZE_W){1'b0}}, sb.size_reg})
        begin
            $display("%0t: table_size readback expected %0d actual %0d",
                     $time, sb.size_reg, rd);
            sb.mismatches++;
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic send_word(input logic [KEY_W-1:0] key,
                             input logic [HANDLE_W-1:0] handle, input int gap);
        in_word_t w;
        w.key           = key;
        w.record_handle = handle;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy);
        sb.note_insert(w);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(0, 3))
            0: return rnd[KEY_W-1:0];
            1: return KEY_W'($urandom_range(0, 47));
            2: return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 47));
            default: return rnd[KEY_W-1:0] & {KEY_W{rnd[0]}} | KEY_W'(rnd[7:1]);
        endcase
    endfunction

    task automatic random_size;
        logic [31:0] value;
        case ($urandom_range(0, 9))
            0: value = 32'd1;
            1: value = 32'd16;
            2: value = 32'd31;
            3: value = 32'd0;
            default: value = $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 7) == 0)
            set_register(ADDR_UNUSED, $urandom);
        set_register(ADDR_TABLE_SIZE, value);
    endtask

    task automatic random_words(input int count, input int idle_pct);
        int gap;
        for (int i = 0; i < count; i++)
        begin
            if (i % 110 == 0)
            begin
                drain();
                random_size();
            end
            gap = 0;
            if ($urandom_range(0, 99) < idle_pct)
                gap = $urandom_range(1, 72);
            send_word(pick_key(), $urandom, gap);
        end
        drain();
    endtask

    initial
    begin
        sb      = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-slot table: fill it, then it is full
        set_register(ADDR_TABLE_SIZE, 32'd1);
        send_word('0, '0, 0);
        send_word({KEY_W{1'b1}}, {HANDLE_W{1'b1}}, 0);
        drain();
        // size zero behaves as one
        set_register(ADDR_TABLE_SIZE, 32'd0);
        send_word(31'd5, 32'h1234_5678, 0);
        drain();
        // write to an unused register index must not change anything
        set_register(ADDR_UNUSED, 32'd3);
        send_word(31'd7, 32'h8765_4321, 0);
        drain();
        // probe walk stops at the end of the table without wrapping
        set_register(ADDR_TABLE_SIZE, 32'd3);
        send_word(31'd2, 32'h0000_0001, 0);
        send_word(31'd2, 32'h0000_0002, 0);
        send_word(31'd1, 32'h0000_0003, 0);
        send_word({KEY_W{1'b1}}, 32'h0000_0004, 0);
        drain();
        // oversized register value clamps to the table depth; old entries kept
        set_register(ADDR_TABLE_SIZE, 32'd31);
        send_word(31'd15, 32'hFFFF_0000, 0);
        send_word(31'd31, 32'h0000_FFFF, 0);
        send_word(31'd16, 32'hAAAA_AAAA, 0);
        send_word(31'h2AAA_AAAA, 32'h5555_5555, 0);
        send_word(31'h5555_5555, 32'hAAAA_AAAA, 0);
        drain();
        set_register(ADDR_TABLE_SIZE, 32'd16);
        send_word(31'h7FFF_FFF0, 32'h0F0F_0F0F, 0);
        send_word(31'd14, 32'hF0F0_F0F0, 0);
        drain();

        random_words(550, 19);
        random_words(550, 65);
        random_words(550, 0);

        repeat (80) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
